// File: rtl/pfrc_pkg.sv
// shared types and constants for the page frame reference count table
`default_nettype none

package pfrc_pkg;

    localparam int ADDR_W       = 32;
    localparam int CNT_W        = 8;
    localparam int STATUS_W     = 3;
    localparam int FRAME_SHIFT  = 12;
    localparam int FRAME_NUM_W  = ADDR_W - FRAME_SHIFT;
    localparam int CFG_IDX_W    = 1;

    localparam logic [ADDR_W-1:0] PAGE_MASK     = 32'hFFFF_F000;
    localparam logic [ADDR_W-1:0] LOW_MEM_RESET = 32'h0010_0000;
    localparam logic [CNT_W-1:0]  CNT_MAX       = 8'hFF;

    typedef enum logic [1:0] {
        OP_FREE   = 2'd0,
        OP_SHARE  = 2'd1,
        OP_WFAULT = 2'd2,
        OP_INIT   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BELOW    = 3'd1,
        ST_ABOVE    = 3'd2,
        ST_UNALLOC  = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_MEM  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MEM = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic check;
        logic update;
        logic sweep;
        logic sweep_init;
        logic init_done;
    } pfrc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_init;
        logic sweep_last;
    } pfrc_stat_t;

endpackage

`default_nettype wire

// File: rtl/pfrc_ctrl.sv
// command sequencer for the page frame reference count table
`default_nettype none

module pfrc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire pfrc_pkg::pfrc_stat_t stat,
    output pfrc_pkg::pfrc_cmd_t      cmd
);
    import pfrc_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_CHECK  = 6'b000100,
        S_UPDATE = 6'b001000,
        S_SWEEP  = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take;

    // a new command may land while the previous result is being written back
    assign busy = !((state_reg == S_IDLE) || (state_reg == S_UPDATE) ||
                    (state_reg == S_DONE));
    assign take = start && !busy;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.capture    = take;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                state_next = stat.is_init ? S_SWEEP : S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = take ? S_CHECK : S_IDLE;
            end
            S_SWEEP:
            begin
                cmd.sweep      = 1'b1;
                cmd.sweep_init = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.init_done = 1'b1;
                state_next = take ? S_CHECK : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pfrc_datapath.sv
// count memory, address checks, read-modify-write and table sweep
`default_nettype none

module pfrc_datapath #(
    parameter int PAGE_FRAMES  = 4096,
    parameter int IN_USE_COUNT = 100
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pfrc_pkg::pfrc_cmd_t           cmd,
    output pfrc_pkg::pfrc_stat_t               stat,
    input  wire logic [1:0]                    op,
    input  wire logic [pfrc_pkg::ADDR_W-1:0]   page_address,
    input  wire logic [pfrc_pkg::ADDR_W-1:0]   low_mem,
    input  wire logic [pfrc_pkg::ADDR_W-1:0]   mem_limit,
    output logic                               done,
    output logic [pfrc_pkg::STATUS_W-1:0]      status,
    output logic [pfrc_pkg::CNT_W-1:0]         count_after,
    output logic                               writable_in_place
);
    import pfrc_pkg::*;

    localparam int FW = (PAGE_FRAMES > 1) ? $clog2(PAGE_FRAMES) : 1;
    localparam logic [FW-1:0]          LAST_FRAME = FW'(PAGE_FRAMES - 1);
    localparam logic [FRAME_NUM_W-1:0] FRAME_LIM  = FRAME_NUM_W'(PAGE_FRAMES);
    localparam logic [CNT_W-1:0]       IN_USE     = CNT_W'(IN_USE_COUNT);

    logic [CNT_W-1:0] mem [PAGE_FRAMES];

    op_t                    op_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [FW-1:0]          frame_reg;
    logic                   rej_reg;
    status_t                rej_status_reg;
    logic [CNT_W-1:0]       rd_data_reg;
    logic [FRAME_NUM_W-1:0] first_reg;
    logic [FRAME_NUM_W-1:0] span_reg;
    logic [FW-1:0]          sweep_cnt_reg;
    logic                   done_reg;
    status_t                status_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   wip_reg;

    // check stage
    logic [ADDR_W-1:0]      diff;
    logic [FRAME_NUM_W-1:0] frame_full;
    logic                   addr_lt_low;
    logic                   addr_le_low;
    logic                   addr_ge_high;
    logic                   frame_oob;
    logic                   rej;
    status_t                rej_status;
    logic [ADDR_W-1:0]      high_minus_addr;
    logic [ADDR_W-1:0]      high_minus_low;
    logic                   span_pos;
    logic [FRAME_NUM_W-1:0] span;

    // update stage
    status_t                upd_status;
    logic [CNT_W-1:0]       upd_count;
    logic                   upd_wip;

    // sweep
    logic [FRAME_NUM_W-1:0] sweep_ext;
    logic [FRAME_NUM_W-1:0] sweep_off;
    logic                   in_free_range;

    // memory write port
    logic                   wr_en;
    logic [FW-1:0]          wr_addr;
    logic [CNT_W-1:0]       wr_data;

    assign stat.is_init    = (op_reg == OP_INIT);
    assign stat.sweep_last = (sweep_cnt_reg == LAST_FRAME);

    always_comb
    begin
        diff            = addr_reg - low_mem;
        frame_full      = diff[ADDR_W-1:FRAME_SHIFT];
        addr_lt_low     = addr_reg < low_mem;
        addr_le_low     = addr_reg <= low_mem;
        addr_ge_high    = addr_reg >= mem_limit;
        frame_oob       = frame_full >= FRAME_LIM;

        rej        = 1'b1;
        rej_status = ST_ABOVE;
        if ((op_reg == OP_SHARE) ? addr_le_low : addr_lt_low)
        begin
            rej_status = ST_BELOW;
        end
        else if ((op_reg == OP_FREE) && addr_ge_high)
        begin
            rej_status = ST_ABOVE;
        end
        else if (frame_oob)
        begin
            rej_status = ST_ABOVE;
        end
        else
        begin
            rej        = 1'b0;
            rej_status = ST_OK;
        end

        // init: effective start is the larger of start and low_mem
        high_minus_addr = mem_limit - addr_reg;
        high_minus_low  = mem_limit - low_mem;
        if (addr_lt_low)
        begin
            span_pos = mem_limit > low_mem;
            span     = high_minus_low[ADDR_W-1:FRAME_SHIFT];
        end
        else
        begin
            span_pos = !addr_ge_high;
            span     = high_minus_addr[ADDR_W-1:FRAME_SHIFT];
        end
    end

    always_comb
    begin
        upd_status = ST_OK;
        upd_count  = rd_data_reg;
        upd_wip    = 1'b0;
        case (op_reg)
            OP_FREE:
            begin
                if (rd_data_reg == '0)
                begin
                    upd_status = ST_UNALLOC;
                end
                else
                begin
                    upd_count = rd_data_reg - 1'b1;
                end
            end
            OP_SHARE:
            begin
                if (rd_data_reg == CNT_MAX)
                begin
                    upd_status = ST_OVERFLOW;
                end
                else
                begin
                    upd_count = rd_data_reg + 1'b1;
                end
            end
            OP_WFAULT:
            begin
                if (rd_data_reg == CNT_W'(1))
                begin
                    upd_wip = 1'b1;
                end
                else if (rd_data_reg == '0)
                begin
                    upd_status = ST_UNALLOC;
                end
                else
                begin
                    upd_count = rd_data_reg - 1'b1;
                end
            end
            default:
            begin
                upd_count = '0;
            end
        endcase
        if (rej_reg)
        begin
            upd_status = rej_status_reg;
            upd_count  = '0;
            upd_wip    = 1'b0;
        end
    end

    always_comb
    begin
        sweep_ext     = FRAME_NUM_W'(sweep_cnt_reg);
        sweep_off     = sweep_ext - first_reg;
        in_free_range = (sweep_ext >= first_reg) && (sweep_off < span_reg);

        wr_en   = 1'b0;
        wr_addr = frame_reg;
        wr_data = upd_count;
        if (cmd.sweep)
        begin
            wr_en   = 1'b1;
            wr_addr = sweep_cnt_reg;
            wr_data = (cmd.sweep_init && !in_free_range) ? IN_USE : '0;
        end
        else if (cmd.update && !rej_reg)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.check)
        begin
            rd_data_reg <= mem[frame_full[FW-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op_t'(op);
            addr_reg <= (op_t'(op) == OP_WFAULT) ? (page_address & PAGE_MASK) : page_address;
        end
        if (cmd.check)
        begin
            frame_reg      <= frame_full[FW-1:0];
            rej_reg        <= rej;
            rej_status_reg <= rej_status;
            first_reg      <= addr_lt_low ? '0 : frame_full;
            span_reg       <= span_pos ? span : '0;
        end
        if (cmd.update)
        begin
            status_reg <= upd_status;
            count_reg  <= upd_count;
            wip_reg    <= upd_wip;
        end
        else if (cmd.init_done)
        begin
            status_reg <= ST_OK;
            count_reg  <= '0;
            wip_reg    <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update || cmd.init_done;
            if (cmd.sweep)
            begin
                sweep_cnt_reg <= stat.sweep_last ? '0 : sweep_cnt_reg + 1'b1;
            end
        end
    end

    assign done              = done_reg;
    assign status            = status_reg;
    assign count_after       = count_reg;
    assign writable_in_place = wip_reg;

endmodule

`default_nettype wire

// File: rtl/page_frame_refcount_table.sv
// top level of the page frame reference count table with its register port
// done pulses once the command has passed the check state and the write-back state
// free, share or write fault: check/read, then write back; the next is taken in write back
// init: sweeps the count memory one frame a cycle, done pulses after the sweep ends
// reset: a clearing pass over every frame zeroes every count, busy high meanwhile
// results are not flow controlled: done holds for one cycle only
`default_nettype none

module page_frame_refcount_table #(
    parameter int PAGE_FRAMES  = 4096,
    parameter int IN_USE_COUNT = 100
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    // command transfer
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     op,
    input  wire logic [pfrc_pkg::ADDR_W-1:0]    page_address,

    // result transfer
    output logic                                done,
    output logic [pfrc_pkg::STATUS_W-1:0]       status,
    output logic [pfrc_pkg::CNT_W-1:0]          count_after,
    output logic                                writable_in_place,

    // register write transfer
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pfrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pfrc_pkg::ADDR_W-1:0]    cfg_data
);
    import pfrc_pkg::*;

    pfrc_cmd_t         cmd;
    pfrc_stat_t        stat;

    // managed window registers
    logic [ADDR_W-1:0] low_mem_reg;
    logic [ADDR_W-1:0] mem_limit_reg;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_mem_reg   <= LOW_MEM_RESET;
            mem_limit_reg <= LOW_MEM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LOW_MEM:  low_mem_reg   <= cfg_data;
                CFG_HIGH_MEM: mem_limit_reg <= cfg_data;
                default:      low_mem_reg   <= low_mem_reg;
            endcase
        end
    end

    // sequencing: clearing pass, check, write back, init sweep
    pfrc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // count memory and arithmetic
    pfrc_datapath #(
        .PAGE_FRAMES  (PAGE_FRAMES),
        .IN_USE_COUNT (IN_USE_COUNT)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .op                (op),
        .page_address      (page_address),
        .low_mem           (low_mem_reg),
        .mem_limit         (mem_limit_reg),
        .done              (done),
        .status            (status),
        .count_after       (count_after),
        .writable_in_place (writable_in_place)
    );

endmodule

`default_nettype wire

// File: tb/page_frame_refcount_table_test.sv
// self-checking testbench for the page frame reference count table
module page_frame_refcount_table_test;
    import pfrc_pkg::*;

    localparam int PAGE_FRAMES  = 4096;
    localparam int IN_USE_COUNT = 100;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_REPORTS  = 10;
    // a few quiet cycles after the last result
    localparam int DRAIN_CYCLES = 8;

    // one expected result transfer
    typedef struct {
        status_t    code;
        logic [7:0] count;
        logic       in_place;
    } page_op_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    // command transfer
    logic                 start;
    logic                 busy;
    op_t                  op;
    logic [ADDR_W-1:0]    page_address;

    // result transfer
    logic                 done;
    logic [STATUS_W-1:0]  res_status;
    logic [CNT_W-1:0]     res_count;
    logic                 res_in_place;

    // register write transfer
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    // shadow of the block: counts and window registers
    logic [7:0]           frame_refs [PAGE_FRAMES];
    logic [31:0]          low_mem_reg;
    logic [31:0]          high_mem_reg;

    page_op_result_t      expected_results [$];

    int unsigned          cycle_count;
    int unsigned          command_count;
    int unsigned          init_count;
    int unsigned          reg_write_count;
    int unsigned          results_checked;
    int unsigned          mismatch_count;
    int unsigned          burst_left;
    int unsigned          status_seen [5];
    int unsigned          in_place_seen;

    page_frame_refcount_table #(
        .PAGE_FRAMES      (PAGE_FRAMES),
        .IN_USE_COUNT     (IN_USE_COUNT)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .op               (op),
        .page_address     (page_address),
        .done             (done),
        .status           (res_status),
        .count_after      (res_count),
        .writable_in_place(res_in_place),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #6 clk = ~clk;

    // watchdog, counts every cycle from time zero
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, expected_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // predicts the result of one command and updates the shadow counts
    task automatic apply_page_op(input op_t kind, input logic [31:0] addr,
                                 output page_op_result_t res);
        logic [31:0] masked;
        logic [31:0] fidx;
        logic [31:0] eff;
        logic [31:0] first;
        logic [31:0] span;
        int unsigned i;
        res.code     = ST_OK;
        res.count    = '0;
        res.in_place = 1'b0;
        case (kind)
            OP_FREE:
            begin
                fidx = (addr - low_mem_reg) >> FRAME_SHIFT;
                if (addr < low_mem_reg)
                    res.code = ST_BELOW;
                else if (addr >= high_mem_reg || fidx >= PAGE_FRAMES)
                    res.code = ST_ABOVE;
                else
                begin
                    // a free of an unused frame is flagged, never wrapped
                    if (frame_refs[fidx] == '0)
                        res.code = ST_UNALLOC;
                    else
                        frame_refs[fidx] = frame_refs[fidx] - 1'b1;
                    res.count = frame_refs[fidx];
                end
            end
            OP_SHARE:
            begin
                fidx = (addr - low_mem_reg) >> FRAME_SHIFT;
                if (addr <= low_mem_reg)
                    res.code = ST_BELOW;
                else if (fidx >= PAGE_FRAMES)
                    res.code = ST_ABOVE;
                else
                begin
                    // saturates at the top count
                    if (frame_refs[fidx] == CNT_MAX)
                        res.code = ST_OVERFLOW;
                    else
                        frame_refs[fidx] = frame_refs[fidx] + 1'b1;
                    res.count = frame_refs[fidx];
                end
            end
            OP_WFAULT:
            begin
                masked = addr & PAGE_MASK;
                fidx   = (masked - low_mem_reg) >> FRAME_SHIFT;
                if (masked < low_mem_reg)
                    res.code = ST_BELOW;
                else if (fidx >= PAGE_FRAMES)
                    res.code = ST_ABOVE;
                else
                begin
                    // sole owner keeps the page, otherwise it is copied
                    if (frame_refs[fidx] == 8'd1)
                        res.in_place = 1'b1;
                    else if (frame_refs[fidx] == '0)
                        res.code = ST_UNALLOC;
                    else
                        frame_refs[fidx] = frame_refs[fidx] - 1'b1;
                    res.count = frame_refs[fidx];
                end
            end
            default:
            begin
                // everything in use, then the free window cleared
                eff   = (addr < low_mem_reg) ? low_mem_reg : addr;
                first = (eff - low_mem_reg) >> FRAME_SHIFT;
                span  = (high_mem_reg > eff) ? (high_mem_reg - eff) >> FRAME_SHIFT : '0;
                for (i = 0; i < PAGE_FRAMES; i++)
                    frame_refs[i] = 8'(IN_USE_COUNT);
                for (i = 0; i < span && first + i < PAGE_FRAMES; i++)
                begin
                    frame_refs[first + i] = '0;
                end
            end
        endcase
    endtask

    // one command transfer, with a random hold-off in front of it
    task automatic send_page_op(input op_t kind, input logic [31:0] addr);
        int unsigned gap;
        page_op_result_t want;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 18);
            if ($urandom_range(0, 19) == 0)
                burst_left = $urandom_range(5, 20);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start        <= 1'b1;
        op           <= kind;
        page_address <= addr;
        do @(posedge clk); while (busy !== 1'b0);
        apply_page_op(kind, addr, want);
        expected_results.push_back(want);
        command_count++;
        if (kind == OP_INIT)
            init_count++;
    endtask

    // drop start and let every outstanding result arrive
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0 || busy !== 1'b0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one register write transfer, only called while idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        if (idx == CFG_LOW_MEM)
            low_mem_reg = val;
        else
            high_mem_reg = val;
        reg_write_count++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_window(input logic [31:0] lo, input logic [31:0] hi);
        wait_idle();
        write_reg(CFG_LOW_MEM, lo);
        write_reg(CFG_HIGH_MEM, hi);
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // result checker, compares each strobed result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        page_op_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result with none expected, status %0d count %0d",
                                          res_status, res_count));
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                status_seen[want.code]++;
                if (want.in_place)
                    in_place_seen++;
                if (res_status !== want.code)
                    report_mismatch($sformatf("status expected %0d actual %0d",
                                              want.code, res_status));
                if (res_count !== want.count)
                    report_mismatch($sformatf("count_after expected %0d actual %0d",
                                              want.count, res_count));
                if (res_in_place !== want.in_place)
                    report_mismatch($sformatf("writable_in_place expected %0d actual %0d",
                                              want.in_place, res_in_place));
            end
        end
    end

    // corner cases under the reset window, then a small window of sixteen frames and an unaligned one
    task automatic test_boundary_cases();
        wait_idle();
        send_page_op(OP_FREE,   32'h0000_0000);  // below low_mem
        send_page_op(OP_FREE,   32'hFFFF_FFFF);  // past the memory limit
        send_page_op(OP_FREE,   32'h0010_0000);  // exactly at the memory limit
        send_page_op(OP_SHARE,  32'h0010_0000);  // share at low_mem is ignored
        send_page_op(OP_SHARE,  32'h0010_0001);  // frame 0 goes to one
        send_page_op(OP_WFAULT, 32'h0010_0FFF);  // sole owner, offset masked off
        send_page_op(OP_SHARE,  32'hFFFF_FFFF);  // frame beyond the table
        send_page_op(OP_WFAULT, 32'h0000_0000);  // below low_mem
        send_page_op(OP_WFAULT, 32'h0020_0000);  // unused frame
        send_page_op(OP_SHARE,  32'h0010_0002);
        send_page_op(OP_WFAULT, 32'h0010_0000);  // shared, copy and decrement
        send_page_op(OP_INIT,   32'h0000_0000);  // empty window, nothing freed

        set_window(32'h0010_0000, 32'h0011_0000);
        send_page_op(OP_INIT,   32'h0000_0000);  // start below low_mem
        send_page_op(OP_FREE,   32'h0010_0000);  // freed frame
        send_page_op(OP_FREE,   32'h0011_0000);
        send_page_op(OP_INIT,   32'h0010_4000);  // first four frames stay in use
        send_page_op(OP_FREE,   32'h0010_0000);
        send_page_op(OP_INIT,   32'h0011_0000);  // start at the memory limit
        send_page_op(OP_WFAULT, 32'h0010_1234);

        // unaligned low_mem, so masking drops a fault below it
        set_window(32'h0010_0800, 32'h0020_0000);
        send_page_op(OP_WFAULT, 32'h0010_0900);
        send_page_op(OP_SHARE,  32'h0010_0801);
    endtask

    // whole address space as window, then an inverted window
    task automatic test_config_extremes();
        set_window(32'h0000_0000, 32'hFFFF_FFFF);
        send_page_op(OP_INIT,   32'h0000_0000);  // every frame freed
        send_page_op(OP_FREE,   32'h00FF_F000);  // last frame
        send_page_op(OP_FREE,   32'h0100_0000);  // first frame past the table

        set_window(32'hFFFF_FFFF, 32'h0000_0000);
        send_page_op(OP_SHARE,  32'hFFFF_FFFF);
        send_page_op(OP_FREE,   32'hFFFF_FFFF);
        send_page_op(OP_WFAULT, 32'hFFFF_FFFF);
        send_page_op(OP_INIT,   32'h0000_0000);
    endtask

    // push one in-use frame up through the top count
    task automatic test_share_saturation();
        int unsigned n;
        set_window(32'h0010_0000, 32'h0014_0000);
        send_page_op(OP_INIT, 32'h0010_1000);
        for (n = 0; n < 158; n++)
            send_page_op(OP_SHARE, 32'h0010_0000 + $urandom_range(1, 4095));
        for (n = 0; n < 4; n++)
            send_page_op(OP_WFAULT, 32'h0010_0000 + $urandom_range(0, 4095));
    endtask

    // mostly commands aimed at a few hot frames, with some wild addresses
    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned n;
        int unsigned pick;
        int unsigned frame;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] addr;
        op_t         kind;
        for (phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
                lo = 32'h0;
            else
                lo = ($urandom_range(0, 4095) << 20)
                   | ($urandom_range(0, 1) ? $urandom_range(0, 4095) : 0);
            hi = lo + ($urandom_range(8, 48) << FRAME_SHIFT) + $urandom_range(0, 4095);
            if (phase == 5)
            begin
                lo = $urandom;
                hi = $urandom;
            end
            set_window(lo, hi);
            send_page_op(OP_INIT, lo + ($urandom_range(0, 6) << FRAME_SHIFT));
            for (n = 0; n < 44; n++)
            begin
                pick = $urandom_range(0, 99);
                case ($urandom_range(0, 2))
                    0:       kind = OP_FREE;
                    1:       kind = OP_SHARE;
                    default: kind = OP_WFAULT;
                endcase
                if (pick < 2)
                begin
                    kind = OP_INIT;
                    addr = lo + ($urandom_range(0, 20) << FRAME_SHIFT);
                end
                else if (pick < 88)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50)
                        frame = $urandom_range(0, 7);
                    else if (pick < 70)
                        frame = $urandom_range(0, 47);
                    else if (pick < 85)
                        frame = $urandom_range(PAGE_FRAMES - 8, PAGE_FRAMES - 1);
                    else
                        frame = $urandom_range(PAGE_FRAMES, PAGE_FRAMES + 100);
                    addr = lo + (frame << FRAME_SHIFT) + $urandom_range(0, 4095);
                end
                else
                    addr = $urandom;
                send_page_op(kind, addr);
            end
        end
    endtask

    initial
    begin
        start        = 1'b0;
        op           = OP_FREE;
        page_address = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_LOW_MEM;
        cfg_data     = '0;
        cycle_count     = 0;
        command_count   = 0;
        init_count      = 0;
        reg_write_count = 0;
        results_checked = 0;
        mismatch_count  = 0;
        burst_left      = 0;
        in_place_seen   = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        foreach (frame_refs[i])
            frame_refs[i] = '0;
        low_mem_reg  = LOW_MEM_RESET;
        high_mem_reg = LOW_MEM_RESET;

        // single reset at the start, released on a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_boundary_cases();
        test_config_extremes();
        test_share_saturation();
        test_random_traffic();

        wait_idle();

        $display("covered %0d commands (%0d inits) over %0d register writes, %0d results checked",
                 command_count, init_count, reg_write_count, results_checked);
        $display("status mix: ok %0d below %0d above %0d unallocated %0d overflow %0d, in place %0d",
                 status_seen[ST_OK], status_seen[ST_BELOW], status_seen[ST_ABOVE],
                 status_seen[ST_UNALLOC], status_seen[ST_OVERFLOW], in_place_seen);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
